/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in scope for the short form
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define DWRD_ASSERT_CLK(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) else $error(msg);

// short form on clk and rst_n
`define DWRD_ASSERT(lbl, prop, msg) \
  `DWRD_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

/* rtl/dwrd_pkg.sv */
// shared types and constants of the draw-without-repeat deck
// no dependencies; used by the controller, the datapath and the top level
`default_nettype none

package dwrd_pkg;

  localparam int DFLT_MAX_ENTRIES = 16;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int ENTRY_W = 16;
  localparam int PICK_W  = 16;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0]   DFLT_ACTIVE_COUNT = 5'd16;
  localparam logic [ENTRY_W-1:0] EMPTY_MARK        = 16'hFFF0;
  localparam logic [ENTRY_W-1:0] DRAWN_MASK        = 16'h8000;
  localparam logic [ENTRY_W-1:0] VALUE_MASK        = 16'h7FFF;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_COUNT = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch a new transaction
    logic scan;    // read and evaluate deck entries
    logic refill;  // evaluation clears drawn bits instead of counting
    logic rewind;  // restart the entry pointer
    logic load;    // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_scan;     // operation walks the deck
    logic pass_done;   // every entry of the pass evaluated
    logic hit;         // draw found its entry this cycle
    logic refill_due;  // count saw no undrawn entry
    logic out_busy;    // output register still holds an untaken result
  } sts_t;

endpackage

`default_nettype wire

/* rtl/dwrd_ctrl.sv */
// controller state machine of the deck: sequences accept, scan, refill, result
// depends on dwrd_pkg (cmd_t, sts_t)
`default_nettype none

module dwrd_ctrl import dwrd_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REFILL,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = sts.op_scan;
        if (!sts.op_scan || sts.hit) begin
          state_nxt = ST_FIN;
        end else if (sts.pass_done) begin
          if (sts.refill_due) begin
            cmd.rewind = 1'b1;
            state_nxt  = ST_REFILL;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_REFILL: begin
        cmd.scan   = 1'b1;
        cmd.refill = 1'b1;
        if (sts.pass_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

`default_nettype wire

/* rtl/dwrd_dp.sv */
// datapath of the deck: entry memory, scan pointer, counters, result register
// depends on dwrd_pkg (cmd_t, sts_t, op_t, entry constants)
`default_nettype none

module dwrd_dp import dwrd_pkg::*; #(
  parameter int MAX_ENTRIES = DFLT_MAX_ENTRIES
) (
  input  wire                clk,
  input  wire                rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  wire [OP_W-1:0]     in_opcode,
  input  wire [IDX_W-1:0]    in_entry_index,
  input  wire [ENTRY_W-1:0]  in_entry_value,
  input  wire [PICK_W-1:0]   in_pick,
  input  wire [CNT_W-1:0]    active_count,
  input  wire                out_ready,
  output logic               out_valid,
  output logic [CNT_W-1:0]   res_remaining,
  output logic [CNT_W-1:0]   res_used,
  output logic [ENTRY_W-1:0] res_drawn,
  output logic               res_found
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = (CW > CNT_W) ? CW : CNT_W;

  logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rd_data_r;

  op_t                op_r;
  logic [PICK_W-1:0]  pick_r;
  logic [CW-1:0]      n_r;
  logic [CW-1:0]      k_r;
  logic               ev_vld_r;
  logic [IW-1:0]      ev_addr_r;
  logic [CW-1:0]      used_r;
  logic [CW-1:0]      rem_r;
  logic [ENTRY_W-1:0] drawn_r;
  logic               found_r;
  logic               out_valid_r;

  logic [SW-1:0]      ac_ext;
  logic [CW-1:0]      n_sat;
  logic               idx_ok;
  logic               issue;
  logic               eval;
  logic               count_eval;
  logic               undrawn;
  logic               hit;
  logic               we;
  logic [IW-1:0]      wa;
  logic [ENTRY_W-1:0] wd;

  // active count saturates at the deck depth
  assign ac_ext = SW'(active_count);
  assign n_sat  = (ac_ext > SW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(ac_ext);
  assign idx_ok = (32'(in_entry_index) < 32'(MAX_ENTRIES));

  assign undrawn    = ~rd_data_r[ENTRY_W-1];
  assign issue      = cmd.scan && !cmd.rewind && (k_r != n_r);
  assign eval       = cmd.scan && ev_vld_r;
  assign count_eval = eval && !cmd.refill;
  // undrawn entries seen so far equal the pick, so this one is the picked entry
  assign hit        = count_eval && (op_r == OP_DRAW) && undrawn &&
                      (PICK_W'(rem_r) == pick_r);

  always_comb begin
    we = 1'b0;
    wa = ev_addr_r;
    wd = rd_data_r;
    if (cmd.start && (op_t'(in_opcode) == OP_WRITE) && idx_ok) begin
      we = 1'b1;
      wa = IW'(in_entry_index);
      wd = in_entry_value;
    end else if (eval && cmd.refill) begin
      we = 1'b1;
      wd = rd_data_r & VALUE_MASK;
    end else if (hit) begin
      we = 1'b1;
      wd = rd_data_r | DRAWN_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rd_data_r <= mem[k_r[IW-1:0]];
      ev_addr_r <= k_r[IW-1:0];
    end
  end

  // scan pointer and read pipeline flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r      <= '0;
      ev_vld_r <= 1'b0;
    end else if (cmd.start || cmd.rewind) begin
      k_r      <= '0;
      ev_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      ev_vld_r <= issue;
      if (issue) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= op_t'(in_opcode);
      pick_r  <= in_pick;
      n_r     <= n_sat;
      used_r  <= '0;
      rem_r   <= '0;
      drawn_r <= in_pick;
      found_r <= 1'b0;
    end else if (count_eval) begin
      if (rd_data_r != EMPTY_MARK) begin
        used_r <= used_r + 1'b1;
      end
      if (undrawn) begin
        rem_r <= rem_r + 1'b1;
      end
      if (hit) begin
        drawn_r <= rd_data_r;
        found_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_remaining <= '0;
      res_used      <= '0;
      res_drawn     <= '0;
      res_found     <= 1'b0;
      case (op_r)
        OP_COUNT: begin
          res_remaining <= (rem_r == '0) ? CNT_W'(n_r) : CNT_W'(rem_r);
          res_used      <= CNT_W'(used_r);
        end
        OP_DRAW: begin
          res_drawn <= drawn_r;
          res_found <= found_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  assign sts.op_scan    = (op_r == OP_COUNT) || (op_r == OP_DRAW);
  assign sts.pass_done  = (k_r == n_r) && !ev_vld_r;
  assign sts.hit        = hit;
  assign sts.refill_due = (op_r == OP_COUNT) && (rem_r == '0);
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

`default_nettype wire

/* rtl/draw_without_repeat_deck.sv */
// throughput: one transaction at a time, one deck entry scanned per cycle on a
//   single read port; the next input is taken while a result waits
// reset: synchronous active-low; active count returns to 16, deck contents kept
`default_nettype none

module draw_without_repeat_deck import dwrd_pkg::*; #(
  parameter int MAX_ENTRIES = DFLT_MAX_ENTRIES
) (
  input  wire               clk,
  input  wire               rst_n,
  // input stream
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire [39:0]        in_tdata,   // entry_index, entry_value, pick, zero pad
  input  wire [OP_W-1:0]    in_tuser,   // opcode
  // result stream
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [31:0]       out_tdata,  // remaining, used_slots, drawn_value, zero pad
  output logic              out_tuser,  // found
  // configuration write
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [CNT_W-1:0]   cfg_data    // active_count
);

  cmd_t cmd;
  sts_t sts;

  logic [CNT_W-1:0]   active_count_r;
  logic [CNT_W-1:0]   res_remaining;
  logic [CNT_W-1:0]   res_used;
  logic [ENTRY_W-1:0] res_drawn;
  logic               res_found;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= DFLT_ACTIVE_COUNT;
    end else if (cfg_valid) begin
      active_count_r <= cfg_data;
    end
  end

  dwrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwrd_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_tuser),
    .in_entry_index (in_tdata[3:0]),
    .in_entry_value (in_tdata[19:4]),
    .in_pick        (in_tdata[35:20]),
    .active_count   (active_count_r),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .res_remaining  (res_remaining),
    .res_used       (res_used),
    .res_drawn      (res_drawn),
    .res_found      (res_found)
  );

  assign out_tdata = {6'd0, res_drawn, res_used, res_remaining};
  assign out_tuser = res_found;

endmodule

`default_nettype wire

/* rtl/dwrd_checker.sv */
// port-level checker of the deck, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dwrd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser
);

  `DWRD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `DWRD_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed while stalled")
  `DWRD_ASSERT(a_found_no_count, out_tvalid && out_tuser |-> out_tdata[9:0] == 10'd0, "draw result carries count fields")
  `DWRD_ASSERT(a_one_kind, out_tvalid |-> out_tdata[4:0] == 5'd0 || out_tdata[25:10] == 16'd0, "count and draw fields both set")
  `DWRD_ASSERT(a_no_instant, in_tvalid && in_tready && !out_tvalid |=> !out_tvalid, "result in the cycle after accept")

endmodule

bind draw_without_repeat_deck dwrd_checker u_dwrd_checker (.*);

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench of the draw-without-repeat deck on its stream ports
// depends on dwrd_pkg and draw_without_repeat_deck; a shadow deck predicts each result
`timescale 1ns / 100ps

module tb_top;
  import dwrd_pkg::*;

  typedef struct {
    logic [CNT_W-1:0]   remaining;
    logic [CNT_W-1:0]   used_slots;
    logic [ENTRY_W-1:0] drawn_value;
    logic               found;
  } deck_answer_t;

  // shadow copy of the deck and the active count, plus the answers still owed
  class deck_shadow;
    logic [ENTRY_W-1:0] entries [16];
    logic [CNT_W-1:0]   active_count = DFLT_ACTIVE_COUNT;
    deck_answer_t       owed [$];
    int                 errors = 0;

    function int live();
      return (active_count > 16) ? 16 : int'(active_count);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void set_active(logic [CNT_W-1:0] v);
      active_count = v;
    endfunction

    function void accept_op(op_t op, logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] val,
                            logic [PICK_W-1:0] pick);
      deck_answer_t a;
      int n;
      int ord;
      n = live();
      a.remaining = '0;
      a.used_slots = '0;
      a.drawn_value = '0;
      a.found = 1'b0;
      case (op)
        OP_WRITE: begin
          entries[idx] = val;
        end
        OP_COUNT: begin
          for (int k = 0; k < n; k++) begin
            if (entries[k] != EMPTY_MARK) a.used_slots++;
            if ((entries[k] & DRAWN_MASK) == '0) a.remaining++;
          end
          // nothing left: put every active entry back, empty slots too
          if (a.remaining == '0) begin
            for (int k = 0; k < n; k++) entries[k] = entries[k] & VALUE_MASK;
            a.remaining = CNT_W'(n);
          end
        end
        OP_DRAW: begin
          ord = 0;
          a.drawn_value = pick;
          for (int k = 0; k < n; k++) begin
            if ((entries[k] & DRAWN_MASK) == '0) begin
              if (ord == int'(pick)) begin
                a.drawn_value = entries[k];
                entries[k] = entries[k] | DRAWN_MASK;
                a.found = 1'b1;
                break;
              end
              ord++;
            end
          end
        end
        default: ;
      endcase
      owed.push_back(a);
    endfunction

    function void flag(string field, longint unsigned exp_v, longint unsigned act_v);
      $display("%0t mismatch %s: expected %0h actual %0h", $time, field, exp_v, act_v);
      errors++;
    endfunction

    function void check_answer(logic [31:0] data, logic flag_bit);
      deck_answer_t a;
      if (owed.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h/%b", $time, data, flag_bit);
        errors++;
        return;
      end
      a = owed.pop_front();
      if (data[4:0] !== a.remaining) flag("remaining", a.remaining, data[4:0]);
      if (data[9:5] !== a.used_slots) flag("used_slots", a.used_slots, data[9:5]);
      if (data[25:10] !== a.drawn_value) flag("drawn_value", a.drawn_value, data[25:10]);
      if (flag_bit !== a.found) flag("found", a.found, flag_bit);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [39:0]        in_tdata;   // entry_index, entry_value, pick, zero pad
  logic [OP_W-1:0]    in_tuser;   // opcode
  logic               out_tvalid;
  logic               out_tready;
  logic [31:0]        out_tdata;  // remaining, used_slots, drawn_value, zero pad
  logic               out_tuser;  // found
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CNT_W-1:0]   cfg_data;   // active_count

  deck_shadow book = new;
  bit         no_idle = 1'b0;

  draw_without_repeat_deck dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // called right after a rising edge; returns at the edge that took the transaction
  task automatic send_op(op_t op, logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] val,
                         logic [PICK_W-1:0] pick);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, pick, val, idx};
    do @(posedge clk); while (!in_tready);
    book.accept_op(op, idx, val, pick);
  endtask

  // hold off until every owed result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_active(logic [CNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.set_active(v);
  endtask

  task automatic random_ops(int count);
    int roll;
    op_t op;
    logic [ENTRY_W-1:0] val;
    logic [PICK_W-1:0] pick;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 25) op = OP_WRITE;
      else if (roll < 45) op = OP_COUNT;
      else if (roll < 95) op = OP_DRAW;
      else op = OP_NOP;
      case ($urandom_range(0, 3))
        0: val = EMPTY_MARK;
        1: val = 16'($urandom) | DRAWN_MASK;
        default: val = 16'($urandom);
      endcase
      // mostly picks from zero to one past the active count, some far beyond it
      if ($urandom_range(0, 4) == 0) pick = 16'($urandom);
      else pick = 16'($urandom_range(0, book.live() + 1));
      send_op(op, 4'($urandom), val, pick);
    end
    no_idle = 1'b0;
  endtask

  // result side
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      book.check_answer(out_tdata, out_tuser);
    end
  end

  initial begin
    logic [CNT_W-1:0] settings [8];
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_NOP;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load the whole deck first so no scan ever touches an unwritten entry
    send_op(OP_WRITE, 4'd0, 16'h0000, 16'h0000);
    send_op(OP_WRITE, 4'd1, 16'hFFFF, 16'hFFFF);
    send_op(OP_WRITE, 4'd2, EMPTY_MARK, 16'h0000);
    send_op(OP_WRITE, 4'd3, 16'h7FFF, 16'h0000);
    send_op(OP_WRITE, 4'd4, 16'h8000, 16'h0000);
    for (int k = 5; k < 16; k++)
      send_op(OP_WRITE, 4'(k), 16'(16'h1111 * k), 16'h0000);
    send_op(OP_COUNT, 4'hF, 16'hFFFF, 16'hFFFF);
    send_op(OP_DRAW, 4'h0, 16'h0000, 16'h0000);
    send_op(OP_DRAW, 4'h0, 16'h0000, 16'hFFFF);
    send_op(OP_DRAW, 4'hF, 16'hFFFF, 16'h0003);
    send_op(OP_NOP, 4'hF, 16'hFFFF, 16'hFFFF);
    send_op(OP_COUNT, 4'h0, 16'h0000, 16'h0000);

    random_ops(100);

    settings = '{5'd0, 5'd31, 5'd1, 5'd2, 5'd16, 5'd7, 5'($urandom), 5'd16};
    foreach (settings[s]) begin
      write_active(settings[s]);
      random_ops(140);
    end

    drain();
    if (book.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
